// ===== src/olb_pkg.sv =====
// Package for the ordered list buffer: shared types and fixed field widths.
`default_nettype none

package olb_pkg;

   // Fixed payload widths
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 4;

   // Request operation
   typedef enum logic [1:0] {
      FN_APPEND    = 2'd0,
      FN_REM_HEAD  = 2'd1,
      FN_REM_TAIL  = 2'd2,
      FN_REM_INDEX = 2'd3
   } func_type;

   // Result status
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   // Sequencer state
   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_FETCH = 2'd1,
      S_SHIFT = 2'd2
   } state_type;

endpackage

`default_nettype wire

// ===== src/olb_chan_if.sv =====
// Valid/ready channel interfaces for the ordered list buffer requests and results.
`default_nettype none

interface olb_req_if;
   logic                                 valid;
   logic                                 ready;
   olb_pkg::func_type                    func;
   logic signed [olb_pkg::VALUE_W-1:0]   value;
   logic        [olb_pkg::INDEX_W-1:0]   index;

   modport source (output valid, output func, output value, output index, input ready);
   modport sink   (input valid, input func, input value, input index, output ready);
endinterface

interface olb_rsp_if #(parameter int CNT_W = 5);
   logic                                 valid;
   logic                                 ready;
   logic signed [olb_pkg::VALUE_W-1:0]   removed_value;
   logic        [CNT_W-1:0]              item_count;
   olb_pkg::status_type                  status;

   modport source (output valid, output removed_value, output item_count, output status,
                   input ready);
   modport sink   (input valid, input removed_value, input item_count, input status,
                   output ready);
endinterface

`default_nettype wire

// ===== src/ordered_list_buffer.sv =====
// Ordered list buffer: compacted list with append and head, tail or indexed removal.
//
//   channel  dir  handshake      payload
//   req_bus  in   valid/ready    func, value, index
//   rsp_bus  out  valid/ready    removed_value, item_count, status
//
// Append and every rejected request go straight to the result register.
// A removal reads the removed entry in S_FETCH, then moves each later entry down one place
// in S_SHIFT through the one read port and one write port of the entry RAM.
// Reset empties the list; RAM contents are not cleared. req_bus.ready is low while a
// removal is in progress or a result waits with rsp_bus.ready low.
`default_nettype none

module ordered_list_buffer #(
   parameter int CAPACITY = 16
) (
   input wire logic clock,
   input wire logic reset,
   olb_req_if.sink   req_bus,
   olb_rsp_if.source rsp_bus
);
   import olb_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [VALUE_W-1:0] removed_ff, removed_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [VALUE_W-1:0] rd_data;

   logic               req_accept;
   logic [CMP_W-1:0]   idx_ext;
   logic [CMP_W-1:0]   cnt_ext;
   logic [CNT_W-1:0]   next_pos;

   olb_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Accept only when idle and the result slot is free or draining
   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign idx_ext  = CMP_W'(req_bus.index);
   assign cnt_ext  = CMP_W'(count_ff);
   assign next_pos = CNT_W'(ptr_ff) + CNT_W'(1);

   // Sequence requests: decide, fetch the removed entry, shift later entries down
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      wr_addr        = ptr_ff;
      wr_data        = rd_data;
      rd_addr        = next_pos[IDX_W-1:0];

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_removed_in = '0;
               rsp_count_in   = count_ff;
               case (req_bus.func)
                  FN_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = count_ff[IDX_W-1:0];
                        wr_data       = req_bus.value;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_count_in  = count_ff + CNT_W'(1);
                        rsp_status_in = ST_OK;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else if (req_bus.func == FN_REM_HEAD) begin
                        ptr_in   = '0;
                        rd_addr  = '0;
                        state_in = S_FETCH;
                     end else if (req_bus.func == FN_REM_TAIL) begin
                        ptr_in   = IDX_W'(count_ff - CNT_W'(1));
                        rd_addr  = IDX_W'(count_ff - CNT_W'(1));
                        state_in = S_FETCH;
                     end else if (idx_ext >= cnt_ext) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_INDEX;
                     end else begin
                        ptr_in   = idx_ext[IDX_W-1:0];
                        rd_addr  = idx_ext[IDX_W-1:0];
                        state_in = S_FETCH;
                     end
                  end
               endcase
            end
         end

         S_FETCH: begin
            // Hold the removed entry, start reading the one after it
            removed_in = rd_data;
            rd_addr    = next_pos[IDX_W-1:0];
            state_in   = S_SHIFT;
         end

         S_SHIFT: begin
            if (next_pos < count_ff) begin
               // Move the next entry down one place
               wr_en   = 1'b1;
               wr_addr = ptr_ff;
               wr_data = rd_data;
               ptr_in  = next_pos[IDX_W-1:0];
               rd_addr = ptr_ff + IDX_W'(2);
            end else begin
               count_in       = count_ff - CNT_W'(1);
               rsp_valid_in   = 1'b1;
               rsp_removed_in = removed_ff;
               rsp_count_in   = count_ff - CNT_W'(1);
               rsp_status_in  = ST_OK;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      removed_ff     <= removed_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.removed_value = rsp_removed_ff;
   assign rsp_bus.item_count    = rsp_count_ff;
   assign rsp_bus.status        = rsp_status_ff;

endmodule

`default_nettype wire

// ===== src/olb_ram.sv =====
// Entry storage: one write port and one read port with registered read data.
`default_nettype none

module olb_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic [olb_pkg::VALUE_W-1:0]   wr_data,
   input  wire logic [ADDR_W-1:0]             rd_addr,
   output      logic [olb_pkg::VALUE_W-1:0]   rd_data
);
   import olb_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one entry, data valid next cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the ordered list buffer: directed and random requests checked against a list model.

module testbench;
   import olb_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int COUNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int RANDOM_ITEMS = 1100;
   localparam int CALM_ITEMS   = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 80;
   localparam int DRAIN_CYCLES = 40;

   typedef logic signed [VALUE_W-1:0] word_type;

   // Result that one request should produce
   typedef struct {
      word_type           removed;
      logic [COUNT_W-1:0] count;
      status_type         status;
   } outcome_type;

   // Tracks the list contents and the results still owed by the block
   class list_scoreboard;
      word_type    held[$];
      outcome_type outcomes[$];
      int          errors = 0;

      // Apply one accepted request to the list and queue its result
      function void note_request(func_type f, word_type v, logic [INDEX_W-1:0] ix);
         outcome_type o;
         o.removed = '0;
         o.status  = ST_OK;
         if (f == FN_APPEND) begin
            if (held.size() >= LIST_DEPTH)
               o.status = ST_FULL;
            else
               held.push_back(v);
         end else if (held.size() == 0) begin
            // empty check comes before the index check
            o.status = ST_EMPTY;
         end else if (f == FN_REM_HEAD) begin
            o.removed = held.pop_front();
         end else if (f == FN_REM_TAIL) begin
            o.removed = held.pop_back();
         end else if (int'(ix) >= held.size()) begin
            o.status = ST_BAD_INDEX;
         end else begin
            o.removed = held[ix];
            held.delete(int'(ix));
         end
         o.count = COUNT_W'(held.size());
         outcomes.push_back(o);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      // Compare one accepted result with the oldest pending one
      task check_result(word_type removed, logic [COUNT_W-1:0] cnt, status_type st);
         outcome_type want;
         if (outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected result: value %0d count %0d status %s",
                                      removed, cnt, st.name()));
            return;
         end
         want = outcomes.pop_front();
         if (removed !== want.removed)
            report_mismatch($sformatf("removed_value %0d, want %0d", removed, want.removed));
         if (cnt !== want.count)
            report_mismatch($sformatf("item_count %0d, want %0d", cnt, want.count));
         if (st !== want.status)
            report_mismatch($sformatf("status %s, want %s", st.name(), want.status.name()));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Stimulus shaping flags
   bit sender_idles = 1'b0;
   bit calm         = 1'b0;
   bit hold_rsp     = 1'b0;

   list_scoreboard sb;

   olb_req_if                    req_bus ();
   olb_rsp_if #(.CNT_W(COUNT_W)) rsp_bus ();

   ordered_list_buffer #(.CAPACITY(LIST_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // Offer one request, with an optional idle burst first, and hold it until accepted
   task automatic send_request(input func_type f, input word_type v,
                               input logic [INDEX_W-1:0] ix);
      if (sender_idles && !calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= f;
      req_bus.value <= v;
      req_bus.index <= ix;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(f, v, ix);
   endtask

   // Pick a value, leaning now and then on the extremes
   function automatic word_type pick_value();
      case ($urandom_range(0, 15))
         0:       return word_type'(32'h8000_0000);
         1:       return word_type'(32'h7FFF_FFFF);
         2:       return '0;
         3:       return '1;
         default: return word_type'($urandom());
      endcase
   endfunction

   // Main stimulus
   initial begin
      bit       grow;
      int       r;
      func_type f;
      logic [INDEX_W-1:0] ix;

      sb = new;
      req_bus.valid <= 1'b0;
      req_bus.func  <= FN_APPEND;
      req_bus.value <= '0;
      req_bus.index <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: removals on an empty list
      send_request(FN_REM_HEAD, word_type'(32'h1234_5678), 4'd0);
      send_request(FN_REM_TAIL, '0, 4'd15);
      send_request(FN_REM_INDEX, '1, 4'd15);
      // Tail of a one-entry list, then index zero on a one-entry list
      send_request(FN_APPEND, word_type'(32'h7FFF_FFFF), 4'd0);
      send_request(FN_REM_TAIL, '0, 4'd0);
      send_request(FN_APPEND, word_type'(32'h8000_0000), 4'd15);
      send_request(FN_REM_INDEX, '0, 4'd0);
      // Fill the list, then append when full
      for (int j = 0; j < LIST_DEPTH; j++) begin
         case (j)
            0:       send_request(FN_APPEND, '1, 4'(j));
            1:       send_request(FN_APPEND, '0, 4'(j));
            2:       send_request(FN_APPEND, word_type'(32'h7FFF_FFFF), 4'(j));
            3:       send_request(FN_APPEND, word_type'(32'h8000_0000), 4'(j));
            default: send_request(FN_APPEND, word_type'($urandom()), 4'(j));
         endcase
      end
      send_request(FN_APPEND, word_type'(32'h5555_AAAA), 4'd0);
      // Last position of a full list, then an index past the end
      send_request(FN_REM_INDEX, '0, 4'd15);
      send_request(FN_REM_INDEX, '0, 4'd15);
      send_request(FN_REM_HEAD, '0, 4'd0);

      // Random: alternate growing and shrinking runs so the count sweeps the whole range
      grow = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0)
            sender_idles = ($urandom_range(0, 2) != 0);
         if (n == 300)
            hold_rsp = 1'b1;
         if (n == RANDOM_ITEMS - CALM_ITEMS)
            calm = 1'b1;

         if (sb.held.size() >= LIST_DEPTH && $urandom_range(0, 2) == 0)
            grow = 1'b0;
         else if (sb.held.size() == 0 && $urandom_range(0, 2) == 0)
            grow = 1'b1;
         else if ($urandom_range(0, 39) == 0)
            grow = !grow;

         r = $urandom_range(0, 99);
         if (r < 10) begin
            // noise: any operation, any index
            case ($urandom_range(0, 3))
               0:       f = FN_APPEND;
               1:       f = FN_REM_HEAD;
               2:       f = FN_REM_TAIL;
               default: f = FN_REM_INDEX;
            endcase
            ix = INDEX_W'($urandom_range(0, 15));
         end else begin
            if ((grow && r < 75) || (!grow && r < 30)) begin
               f = FN_APPEND;
            end else begin
               case ($urandom_range(0, 3))
                  0:       f = FN_REM_HEAD;
                  1:       f = FN_REM_TAIL;
                  default: f = FN_REM_INDEX;
               endcase
            end
            if ($urandom_range(0, 4) != 0 && sb.held.size() > 0)
               ix = INDEX_W'($urandom_range(0, sb.held.size() - 1));
            else
               ix = INDEX_W'($urandom_range(0, 15));
         end
         send_request(f, pick_value(), ix);
      end

      // Drain outstanding results, then let the block settle
      req_bus.valid <= 1'b0;
      while (sb.outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Result side: random stall bursts, one long hold-off, none in the calm stretch
   initial begin
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, calm ? 1 : 30)) @(posedge clock);
      end
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.removed_value, rsp_bus.item_count, rsp_bus.status);
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      wait (!reset);
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
src/olb_pkg.sv
src/olb_chan_if.sv
src/olb_ram.sv
src/ordered_list_buffer.sv
test/testbench.sv
